// File: rtl/hcbd_pkg.sv
// Shared types, codes and helpers for the chunked body decoder.
// No dependencies.
`default_nettype none

package hcbd_pkg;

  localparam int SIZE_BITS = 32;

  typedef logic [SIZE_BITS-1:0] size_t;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_DIGITS  = 3'd1,
    PH_REST    = 3'd2,
    PH_DATA    = 3'd3,
    PH_SKIP    = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    TL_EMPTY = 2'd0,
    TL_CR    = 2'd1,
    TL_OTHER = 2'd2
  } tline_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [1:0] SKIP_BYTES = 2'd2;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  // Decode an ASCII hex digit; valid is low for any other byte.
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: rtl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder, top level.
// Depends on hcbd_pkg.
`default_nettype none

// Takes one body byte per cycle and keeps that rate for as long as the sink
// keeps up. Every byte is decoded in the cycle it is accepted, and any result
// lands in a single output register on acceptance. in_ready stays high while
// that register is empty or being taken. While a word waits on a stalled sink,
// every byte is held back, whether or not it would give a word. Size lines,
// chunk data, the two bytes after each chunk and trailer lines are tracked by
// a small phase machine. A size that would overflow saturates and raises an
// error word for every offending digit. The blank line closing the trailer
// raises a message-complete word.
module http_chunked_body_decoder
  import hcbd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_payload_byte,
  output logic            out_chunk_last
);

  phase_t     phase_r, phase_nxt;
  size_t      acc_r, acc_nxt;
  size_t      remain_r, remain_nxt;
  logic [1:0] skip_r, skip_nxt;
  tline_t     tline_r, tline_nxt;
  logic       digits_r, digits_nxt;

  logic       out_valid_r;
  kind_t      kind_r;
  logic [7:0] byte_r;
  logic       last_r;

  logic       res_valid;
  kind_t      res_kind;
  logic [7:0] res_byte;
  logic       res_last;

  logic       in_fire;
  hex_t       hex;
  logic       ovf;
  size_t      remain_dec;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign hex      = hex_decode(in_data_byte);
  // acc*16 + h exceeds the range exactly when the top nibble is non-zero
  assign ovf      = acc_r[SIZE_BITS-1 -: 4] != 4'd0;
  assign remain_dec = (remain_r != '0) ? remain_r - size_t'(1) : remain_r;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    acc_nxt    = acc_r;
    remain_nxt = remain_r;
    skip_nxt   = skip_r;
    tline_nxt  = tline_r;
    digits_nxt = digits_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_LEAD, PH_DIGITS: begin
          if (phase_r == PH_LEAD &&
              (in_data_byte == CH_SPACE || in_data_byte == CH_TAB)) begin
            phase_nxt = PH_LEAD;
          end else if (hex.valid) begin
            phase_nxt  = PH_DIGITS;
            digits_nxt = 1'b1;
            acc_nxt    = ovf ? '1 : {acc_r[SIZE_BITS-5:0], hex.value};
          end else if (in_data_byte == CH_LF) begin
            if (digits_r && acc_r != '0) begin
              remain_nxt = acc_r;
              phase_nxt  = PH_DATA;
            end else begin
              tline_nxt = TL_EMPTY;
              phase_nxt = PH_TRAILER;
            end
            acc_nxt    = '0;
            digits_nxt = 1'b0;
          end else begin
            phase_nxt = PH_REST;
          end
        end
        PH_REST: begin
          if (in_data_byte == CH_LF) begin
            if (digits_r && acc_r != '0) begin
              remain_nxt = acc_r;
              phase_nxt  = PH_DATA;
            end else begin
              tline_nxt = TL_EMPTY;
              phase_nxt = PH_TRAILER;
            end
            acc_nxt    = '0;
            digits_nxt = 1'b0;
          end
        end
        PH_DATA: begin
          remain_nxt = remain_dec;
          if (remain_dec == '0) begin
            skip_nxt  = SKIP_BYTES;
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = (skip_r != 2'd0) ? skip_r - 2'd1 : skip_r;
          if (skip_r <= 2'd1) begin
            phase_nxt = PH_LEAD;
          end
        end
        PH_TRAILER: begin
          if (in_data_byte == CH_LF) begin
            tline_nxt = TL_EMPTY;
            if (tline_r == TL_CR) begin
              phase_nxt = PH_LEAD;
            end
          end else if (in_data_byte == CH_CR && tline_r == TL_EMPTY) begin
            tline_nxt = TL_CR;
          end else begin
            tline_nxt = TL_OTHER;
          end
        end
        default: begin
          // unused codes behave as the start of a size line: resume there
          phase_nxt = PH_LEAD;
          if (in_data_byte != CH_SPACE && in_data_byte != CH_TAB) begin
            if (hex.valid) begin
              phase_nxt  = PH_DIGITS;
              digits_nxt = 1'b1;
              acc_nxt    = ovf ? '1 : {acc_r[SIZE_BITS-5:0], hex.value};
            end else if (in_data_byte == CH_LF) begin
              if (digits_r && acc_r != '0) begin
                remain_nxt = acc_r;
                phase_nxt  = PH_DATA;
              end else begin
                tline_nxt = TL_EMPTY;
                phase_nxt = PH_TRAILER;
              end
              acc_nxt    = '0;
              digits_nxt = 1'b0;
            end else begin
              phase_nxt = PH_REST;
            end
          end
        end
      endcase
    end
  end

  // result word for the byte being accepted
  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_PAYLOAD;
    res_byte  = 8'd0;
    res_last  = 1'b0;
    unique case (phase_r)
      PH_DATA: begin
        res_valid = 1'b1;
        res_byte  = in_data_byte;
        res_last  = remain_dec == '0;
      end
      PH_TRAILER: begin
        if (in_data_byte == CH_LF && tline_r == TL_CR) begin
          res_valid = 1'b1;
          res_kind  = KIND_COMPLETE;
        end
      end
      PH_REST, PH_SKIP: begin
        res_valid = 1'b0;
      end
      default: begin
        // leading, digit and unused codes: error on a digit that overflows
        if (hex.valid && ovf &&
            !(phase_r == PH_LEAD &&
              (in_data_byte == CH_SPACE || in_data_byte == CH_TAB))) begin
          res_valid = 1'b1;
          res_kind  = KIND_OVERFLOW;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      acc_r       <= '0;
      remain_r    <= '0;
      skip_r      <= 2'd0;
      tline_r     <= TL_EMPTY;
      digits_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      acc_r    <= acc_nxt;
      remain_r <= remain_nxt;
      skip_r   <= skip_nxt;
      tline_r  <= tline_nxt;
      digits_r <= digits_nxt;
      if (in_fire) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the word until taken; load only on an accepted byte with a result
  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      kind_r <= res_kind;
      byte_r <= res_byte;
      last_r <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = byte_r;
  assign out_chunk_last   = last_r;

  a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && last_r |-> kind_r == KIND_PAYLOAD)
    else $error("chunk_last set on a non-payload word");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with an empty output register");

  a_data_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_DATA |=> out_valid_r && kind_r == KIND_PAYLOAD)
    else $error("data byte produced no payload word");

  a_skip_two: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_SKIP && skip_r == SKIP_BYTES |=> phase_r == PH_SKIP)
    else $error("left the skip phase after one byte");

  a_acc_needs_digit: assert property (@(posedge clk) disable iff (!rst_n)
    !digits_r |-> acc_r == '0)
    else $error("size accumulator non-zero with no digits seen");

endmodule

`default_nettype wire
